### design/nqb_pkg.sv
// ----------------------------------------------------------------------------
// nqb_pkg
// Shared types and constants for the N-queens backtracking search block:
// controller commands, datapath status and the register map.
// ----------------------------------------------------------------------------
package nqb_pkg;

	// Fixed widths of the result fields, the configuration register and the APB port.
	localparam int RowFieldW  = 5;
	localparam int ColFieldW  = 5;
	localparam int SizeRegW   = 6;
	localparam int ApbAddrW   = 3;
	localparam int ApbDataW   = 32;

	// Register index of the board size register.
	localparam logic RegBoardSize = 1'b0;

	// Commands issued by the controller to the datapath.
	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_START,
		CMD_TRY,
		CMD_POP_RD,
		CMD_POP,
		CMD_OUT_RD,
		CMD_OUT_LD,
		CMD_FAIL_LD
	} nqb_cmd_t;

	// Status reported by the datapath to the controller.
	typedef struct packed {
		logic done;
		logic exhausted;
		logic row_zero;
		logic out_free;
		logic out_last;
	} nqb_status_t;

endpackage

### design/nqb_ctrl.sv
// ----------------------------------------------------------------------------
// nqb_ctrl
// Controller state machine: sequences the search, the backtrack steps and
// the readout of the placement, one datapath command per cycle.
// ----------------------------------------------------------------------------
module nqb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                start_req,
	input  nqb_pkg::nqb_status_t status,
	output nqb_pkg::nqb_cmd_t    cmd
);
	import nqb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_BACK,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_FAIL
	} state_t;

	state_t state_q;
	state_t state_next;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_next = state_q;
		cmd        = CMD_NOP;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && start_req) begin
					cmd        = CMD_START;
					state_next = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				priority if (status.done) begin
					state_next = ST_OUT_RD;
				end else if (status.exhausted && status.row_zero) begin
					state_next = ST_FAIL;
				end else if (status.exhausted) begin
					cmd        = CMD_POP_RD;
					state_next = ST_BACK;
				end else begin
					cmd = CMD_TRY;
				end
			end
			ST_BACK: begin
				cmd        = CMD_POP;
				state_next = ST_SEARCH;
			end
			ST_OUT_RD: begin
				cmd        = CMD_OUT_RD;
				state_next = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				if (status.out_free) begin
					cmd        = CMD_OUT_LD;
					state_next = status.out_last ? ST_IDLE : ST_OUT_RD;
				end
			end
			ST_FAIL: begin
				if (status.out_free) begin
					cmd        = CMD_FAIL_LD;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// A result is only loaded when the output register can take it.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_OUT_LD || cmd == CMD_FAIL_LD) |-> status.out_free)
		else $error("result loaded while output register is occupied");

	// A search that runs out of columns in the first row reports failure next.
	a_fail_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH && !status.done && status.exhausted && status.row_zero)
		|=> (state_q == ST_FAIL))
		else $error("exhausted search did not enter failure reporting");

endmodule

### design/nqb_dp.sv
// ----------------------------------------------------------------------------
// nqb_dp
// Search datapath: occupancy masks, row and trial counters, the stack of
// chosen columns and the result output register.
// ----------------------------------------------------------------------------
module nqb_dp #(
	parameter int MAX_N = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [nqb_pkg::SizeRegW-1:0]      board_size,
	input  nqb_pkg::nqb_cmd_t                 cmd,
	output nqb_pkg::nqb_status_t              status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [nqb_pkg::RowFieldW-1:0]     row_index,
	output logic [nqb_pkg::ColFieldW-1:0]     queen_column,
	output logic                              last
);
	import nqb_pkg::*;

	localparam int CW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
	localparam int RW = $clog2(MAX_N + 1);
	localparam int SW = RW + 1;
	localparam int DW = $clog2(2 * MAX_N);

	logic [MAX_N-1:0]   col_mask_q;
	logic [2*MAX_N-1:0] rise_mask_q;
	logic [2*MAX_N-1:0] fall_mask_q;
	logic [RW-1:0]      row_q;
	logic [RW-1:0]      trial_q;
	logic [RW-1:0]      out_row_q;
	logic [CW-1:0]      stack_mem [MAX_N];
	logic [CW-1:0]      rdata_q;

	logic [RW-1:0]      n_eff;
	logic [CW-1:0]      col_sel;
	logic [DW-1:0]      rise_idx;
	logic [DW-1:0]      fall_idx;
	logic               is_free;
	logic               rd_en;
	logic [CW-1:0]      rd_addr;

	logic               out_valid_q;
	logic               found_q;
	logic [RowFieldW-1:0] row_index_q;
	logic [ColFieldW-1:0] queen_column_q;
	logic               last_q;

	// Effective board size: zero counts as one, oversize is clamped.
	always_comb begin
		priority if (board_size == '0) begin
			n_eff = RW'(1);
		end else if ({1'b0, board_size} > (SizeRegW + 1)'(MAX_N)) begin
			n_eff = RW'(MAX_N);
		end else begin
			n_eff = RW'(board_size);
		end
	end

	// Square under test: the trial column, or the popped column on backtrack.
	assign col_sel  = (cmd == CMD_POP) ? rdata_q : trial_q[CW-1:0];
	assign rise_idx = DW'(SW'(row_q) + SW'(n_eff) - SW'(col_sel));
	assign fall_idx = DW'(SW'(row_q) + SW'(col_sel));
	assign is_free  = !col_mask_q[col_sel] && !rise_mask_q[rise_idx]
		&& !fall_mask_q[fall_idx];

	// Status back to the controller.
	assign status.done      = (row_q >= n_eff);
	assign status.exhausted = (trial_q >= n_eff);
	assign status.row_zero  = (row_q == '0);
	assign status.out_free  = !out_valid_q || out_ready;
	assign status.out_last  = (out_row_q == n_eff - RW'(1));

	// Counters and occupancy masks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_mask_q  <= '0;
			rise_mask_q <= '0;
			fall_mask_q <= '0;
			row_q       <= '0;
			trial_q     <= '0;
			out_row_q   <= '0;
		end else begin
			unique case (cmd)
				CMD_START: begin
					col_mask_q  <= '0;
					rise_mask_q <= '0;
					fall_mask_q <= '0;
					row_q       <= '0;
					trial_q     <= '0;
					out_row_q   <= '0;
				end
				CMD_TRY: begin
					if (is_free) begin
						col_mask_q[col_sel]   <= 1'b1;
						rise_mask_q[rise_idx] <= 1'b1;
						fall_mask_q[fall_idx] <= 1'b1;
						row_q                 <= row_q + RW'(1);
						trial_q               <= '0;
					end else begin
						trial_q <= trial_q + RW'(1);
					end
				end
				CMD_POP_RD: begin
					row_q <= row_q - RW'(1);
				end
				CMD_POP: begin
					col_mask_q[col_sel]   <= ~col_mask_q[col_sel];
					rise_mask_q[rise_idx] <= ~rise_mask_q[rise_idx];
					fall_mask_q[fall_idx] <= ~fall_mask_q[fall_idx];
					trial_q               <= RW'(rdata_q) + RW'(1);
				end
				CMD_OUT_LD: begin
					out_row_q <= out_row_q + RW'(1);
				end
				CMD_NOP, CMD_OUT_RD, CMD_FAIL_LD: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Stack of chosen columns, one entry per row, with a registered read.
	assign rd_en   = (cmd == CMD_POP_RD) || (cmd == CMD_OUT_RD);
	assign rd_addr = (cmd == CMD_POP_RD) ? CW'(row_q - RW'(1)) : out_row_q[CW-1:0];

	always_ff @(posedge clk) begin
		if (cmd == CMD_TRY && is_free) begin
			stack_mem[row_q[CW-1:0]] <= trial_q[CW-1:0];
		end
		if (rd_en) begin
			rdata_q <= stack_mem[rd_addr];
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == CMD_OUT_LD || cmd == CMD_FAIL_LD) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd == CMD_OUT_LD) begin
			found_q        <= 1'b1;
			row_index_q    <= RowFieldW'(out_row_q);
			queen_column_q <= ColFieldW'(rdata_q);
			last_q         <= status.out_last;
		end else if (cmd == CMD_FAIL_LD) begin
			found_q        <= 1'b0;
			row_index_q    <= '0;
			queen_column_q <= '0;
			last_q         <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign row_index    = row_index_q;
	assign queen_column = queen_column_q;
	assign last         = last_q;

	// Every placed queen occupies exactly one bit in each of the three masks.
	a_mask_balance: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(col_mask_q) == $countones(rise_mask_q))
		&& ($countones(col_mask_q) == $countones(fall_mask_q)))
		else $error("occupancy masks out of balance");

	// A backtrack never pops an empty stack.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_POP_RD) |-> (row_q != '0))
		else $error("stack underflow on backtrack");

endmodule

### design/n_queens_backtrack_solver.sv
// ----------------------------------------------------------------------------
// n_queens_backtrack_solver
// Finds the first placement of N non-attacking queens by depth-first
// bitmask backtracking; N comes from the board size register.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready, start_req) takes one transfer at a
// time while the block is idle. A transfer with start_req = 1 clears the
// masks and runs a fresh search; start_req = 0 is taken and does nothing.
// The output channel (out_valid/out_ready) delivers one transfer per row:
// found = 1, row_index, queen_column, with last set on the final row. When
// no placement exists a single transfer with found = 0 and last = 1 follows.
// Sequence: a search step tests one column; a backtrack step reads the stack
// and then pops it; a result row is read from the stack and then loaded
// into the output register. The search loop tests one square per cycle
// outside backtracking, and the column stack has one registered read port.
// in_ready returns once the last result sits in the output register.
// A stalled receiver holds the result in the output register and the
// readout waits; no result is lost. Reset sets the board size to 8 and
// returns the block to idle with the output channel empty.
// The board size register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module n_queens_backtrack_solver #(
	parameter int MAX_N = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nqb_pkg::ApbAddrW-1:0]      paddr,
	input  logic [nqb_pkg::ApbDataW-1:0]      pwdata,
	output logic [nqb_pkg::ApbDataW-1:0]      prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              start_req,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [nqb_pkg::RowFieldW-1:0]     row_index,
	output logic [nqb_pkg::ColFieldW-1:0]     queen_column,
	output logic                              last
);
	import nqb_pkg::*;

	logic [SizeRegW-1:0] board_size_q;
	logic                reg_sel;
	nqb_cmd_t            cmd;
	nqb_status_t         status;

	// Register decode: one register, word address taken from paddr[2].
	assign reg_sel = (paddr[2] == RegBoardSize);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? ApbDataW'(board_size_q) : '0;

	// Board size register, written on the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_size_q <= SizeRegW'(8);
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			board_size_q <= pwdata[SizeRegW-1:0];
		end
	end

	nqb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.start_req (start_req),
		.status    (status),
		.cmd       (cmd)
	);

	nqb_dp #(
		.MAX_N (MAX_N)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.board_size   (board_size_q),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.row_index    (row_index),
		.queen_column (queen_column),
		.last         (last)
	);

endmodule
